@@ sv/tcw_pkg.sv @@
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants, types and command codes of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // Screen geometry.
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;
  localparam int ADDR_W  = $clog2(CELLS);

  // Field widths.
  localparam int CMD_W  = 2;
  localparam int CHAR_W = 8;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int IDX_W  = 11;
  localparam int ATTR_W = 8;
  localparam int CELL_W = ATTR_W + CHAR_W;

  // Queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Register port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-3:0] REG_TEXT_ATTR = '0;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SETCUR = 2'd2;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd3;

  // Character codes.
  localparam logic [CHAR_W-1:0] CHAR_TAB      = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_LF       = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_CR       = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_SPACE    = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_PRINT_LO = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_PRINT_HI = 8'h7F;
  localparam int                TAB_STEP      = 8;

  localparam logic [ATTR_W-1:0] DEFAULT_ATTR = 8'h07;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [COL_W-1:0]  col_t;
  typedef logic [ROW_W-1:0]  row_t;

  // One classified command, as the back executes it.
  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic              clear;
    logic              scroll;
    logic [CHAR_W-1:0] ch;
    addr_t             addr;
    addr_t             scroll_base;
    col_t              col;
    row_t              row;
  } tcw_op_t;

endpackage

@@ sv/text_console_writer.sv @@
// ----------------------------------------------------------------------------
// text_console_writer
// 80x25 text console: a cell store of attribute/character words, a cursor,
// and commands to write a character, clear, set the cursor and read a cell.
// ----------------------------------------------------------------------------
// Every accepted command beat produces exactly one result beat carrying the
// cursor after the command, the read cell (zero unless the command was an
// in-range read) and a scroll flag. After reset the block blanks all 2000
// cells with attribute 7 and holds in_stall high until that pass ends;
// register writes are taken during it. The front accepts a command into a
// two-entry queue, so a burst of two commands goes in back to back. While
// out_stall is low the back sets the sustained rate: a printable character
// passes fetch, store write and result; a control byte, an ignored byte or
// a set-cursor passes fetch and result; a read passes fetch, store read and
// result; a scroll adds the blanking of one 80-cell row, and a clear walks
// all 2000 cells. The store has one write port, so cells are blanked singly.
// ----------------------------------------------------------------------------
module text_console_writer (
  input  logic                            clk,
  input  logic                            rst_n,
  // Command channel.
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [tcw_pkg::CMD_W-1:0]       in_cmd,
  input  logic [tcw_pkg::CHAR_W-1:0]      in_char_code,
  input  logic [tcw_pkg::COL_W-1:0]       in_new_col,
  input  logic [tcw_pkg::ROW_W-1:0]       in_new_row,
  input  logic [tcw_pkg::IDX_W-1:0]       in_cell_index,
  // Result channel.
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [tcw_pkg::COL_W-1:0]       out_cursor_col,
  output logic [tcw_pkg::ROW_W-1:0]       out_cursor_row,
  output logic [tcw_pkg::CELL_W-1:0]      out_cell_data,
  output logic                            out_scrolled,
  // Register port.
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tcw_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [tcw_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [tcw_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import tcw_pkg::*;

  // The attribute register sits at byte address 0. Only the word index is
  // decoded, so the two low address bits select bytes and are ignored.
  logic [ATTR_W-1:0] text_attr_r;
  logic              attr_sel;
  logic              cfg_write;

  tcw_op_t front_op;
  tcw_op_t q_head;
  logic    front_push;
  logic    q_full;
  logic    q_valid;
  logic    q_pop;
  logic    init_busy;

  assign pready    = 1'b1;
  assign attr_sel  = (paddr[CFG_ADDR_W-1:2] == REG_TEXT_ATTR);
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = attr_sel ? CFG_DATA_W'(text_attr_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_attr_r <= DEFAULT_ATTR;
    end else if (cfg_write && attr_sel) begin
      text_attr_r <= pwdata[ATTR_W-1:0];
    end
  end

  // The front takes no command while the queue is full or while the store
  // is still being blanked after reset.
  tcw_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cmd        (in_cmd),
    .in_char_code  (in_char_code),
    .in_new_col    (in_new_col),
    .in_new_row    (in_new_row),
    .in_cell_index (in_cell_index),
    .busy          (q_full || init_busy),
    .push          (front_push),
    .op            (front_op)
  );

  tcw_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (front_push),
    .push_data  (front_op),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head),
    .head_valid (q_valid)
  );

  // The back drains the queue in order, so a read always sees every write,
  // scroll and clear of the commands before it.
  tcw_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .text_attr      (text_attr_r),
    .q_valid        (q_valid),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .init_busy      (init_busy),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_cursor_col (out_cursor_col),
    .out_cursor_row (out_cursor_row),
    .out_cell_data  (out_cell_data),
    .out_scrolled   (out_scrolled)
  );

endmodule

@@ sv/tcw_ram.sv @@
// ----------------------------------------------------------------------------
// tcw_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ sv/tcw_front.sv @@
// ----------------------------------------------------------------------------
// tcw_front
// Accepts commands, tracks the cursor and the scroll offset, and turns each
// command into one operation for the cell store.
// ----------------------------------------------------------------------------
module tcw_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [tcw_pkg::CMD_W-1:0]    in_cmd,
  input  logic [tcw_pkg::CHAR_W-1:0]   in_char_code,
  input  logic [tcw_pkg::COL_W-1:0]    in_new_col,
  input  logic [tcw_pkg::ROW_W-1:0]    in_new_row,
  input  logic [tcw_pkg::IDX_W-1:0]    in_cell_index,
  input  logic                         busy,
  output logic                         push,
  output tcw_pkg::tcw_op_t             op
);
  import tcw_pkg::*;

  col_t  col_r, col_nxt;
  row_t  row_r, row_nxt;
  addr_t top_base_r, top_base_nxt;

  logic [COL_W:0]  colx;
  logic [ROW_W:0]  rowx;
  logic [COL_W:0]  tab_sum;
  logic [ADDR_W:0] lin_wr;
  logic [ADDR_W:0] lin_rd;
  logic [ADDR_W:0] top_step;

  // Folds a sum of two in-range addresses back into the store.
  function automatic addr_t wrap_addr(input logic [ADDR_W:0] a);
    logic [ADDR_W:0] d;
    d = a - (ADDR_W+1)'(CELLS);
    return (a >= (ADDR_W+1)'(CELLS)) ? d[ADDR_W-1:0] : a[ADDR_W-1:0];
  endfunction

  assign in_stall = busy;
  assign push     = in_valid && !busy;

  assign tab_sum  = {1'b0, col_r} + (COL_W+1)'(TAB_STEP);
  assign lin_wr   = (ADDR_W+1)'(row_r) * (ADDR_W+1)'(COLUMNS) + (ADDR_W+1)'(col_r)
                    + {1'b0, top_base_r};
  assign lin_rd   = (ADDR_W+1)'(in_cell_index) + {1'b0, top_base_r};
  assign top_step = (ADDR_W+1)'(COLUMNS) + {1'b0, top_base_r};

  always_comb begin
    op           = '0;
    op.addr      = wrap_addr(lin_wr);
    op.scroll_base = top_base_r;
    colx         = {1'b0, col_r};
    rowx         = {1'b0, row_r};
    col_nxt      = col_r;
    row_nxt      = row_r;
    top_base_nxt = top_base_r;
    case (in_cmd)
      CMD_WRITE: begin
        if (in_char_code == CHAR_LF) begin
          colx = '0;
          rowx = rowx + (ROW_W+1)'(1);
        end else if (in_char_code == CHAR_CR) begin
          colx = '0;
        end else if (in_char_code == CHAR_TAB) begin
          colx = tab_sum & ~(COL_W+1)'(TAB_STEP - 1);
        end else if (in_char_code inside {[CHAR_PRINT_LO:CHAR_PRINT_HI]}) begin
          op.wr_en = 1'b1;
          op.ch    = in_char_code;
          colx     = colx + (COL_W+1)'(1);
        end
        if (colx >= (COL_W+1)'(COLUMNS)) begin
          colx = '0;
          rowx = rowx + (ROW_W+1)'(1);
        end
        if (rowx >= (ROW_W+1)'(ROWS)) begin
          op.scroll    = 1'b1;
          rowx         = rowx - (ROW_W+1)'(1);
          top_base_nxt = wrap_addr(top_step);
        end
        col_nxt = colx[COL_W-1:0];
        row_nxt = rowx[ROW_W-1:0];
      end
      CMD_CLEAR: begin
        op.clear     = 1'b1;
        col_nxt      = '0;
        row_nxt      = '0;
        top_base_nxt = '0;
      end
      CMD_SETCUR: begin
        if ({1'b0, in_new_col} < (COL_W+1)'(COLUMNS)) begin
          col_nxt = in_new_col;
        end
        if ({1'b0, in_new_row} < (ROW_W+1)'(ROWS)) begin
          row_nxt = in_new_row;
        end
      end
      CMD_READ: begin
        if (32'(in_cell_index) < 32'(CELLS)) begin
          op.rd_en = 1'b1;
          op.addr  = wrap_addr(lin_rd);
        end
      end
      default: begin
      end
    endcase
    op.col = col_nxt;
    op.row = row_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      top_base_r <= '0;
    end else if (push) begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      top_base_r <= top_base_nxt;
    end
  end

endmodule

@@ sv/tcw_queue.sv @@
// ----------------------------------------------------------------------------
// tcw_queue
// Short first-in first-out queue of operations between the front and the back.
// ----------------------------------------------------------------------------
module tcw_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  tcw_pkg::tcw_op_t push_data,
  output logic             full,
  input  logic             pop,
  output tcw_pkg::tcw_op_t head,
  output logic             head_valid
);
  import tcw_pkg::*;

  tcw_op_t             slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]     count_r;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  assign full       = (count_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (QPTR_W+1)'(1);
      end
    end
  end

endmodule

@@ sv/tcw_back.sv @@
// ----------------------------------------------------------------------------
// tcw_back
// Executes queued operations on the cell store: cell writes, row blanking
// on scroll, full-screen clears and cell reads. Owns the result register.
// ----------------------------------------------------------------------------
module tcw_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [tcw_pkg::ATTR_W-1:0]  text_attr,
  input  logic                        q_valid,
  input  tcw_pkg::tcw_op_t            q_head,
  output logic                        q_pop,
  output logic                        init_busy,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [tcw_pkg::COL_W-1:0]   out_cursor_col,
  output logic [tcw_pkg::ROW_W-1:0]   out_cursor_row,
  output logic [tcw_pkg::CELL_W-1:0]  out_cell_data,
  output logic                        out_scrolled
);
  import tcw_pkg::*;

  typedef enum logic [6:0] {
    ST_INIT = 7'b0000001,
    ST_IDLE = 7'b0000010,
    ST_WR   = 7'b0000100,
    ST_SCR  = 7'b0001000,
    ST_CLR  = 7'b0010000,
    ST_RD   = 7'b0100000,
    ST_DONE = 7'b1000000
  } back_state_t;

  back_state_t state_r, state_nxt;
  addr_t       cnt_r, cnt_nxt;
  tcw_op_t     cur_r, cur_nxt;
  logic        out_valid_r, out_valid_nxt;
  col_t        out_col_r;
  row_t        out_row_r;
  logic [CELL_W-1:0] out_cell_r;
  logic        out_scrolled_r;
  logic        load;

  logic              mem_we;
  addr_t             mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic              mem_re;
  logic [CELL_W-1:0] mem_rdata;

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_screen_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (cur_r.addr),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cur_nxt   = cur_r;
    q_pop     = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = cnt_r;
    mem_wdata = {text_attr, CHAR_SPACE};
    mem_re    = 1'b0;
    load      = 1'b0;
    case (state_r)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = {DEFAULT_ATTR, CHAR_SPACE};
        if (cnt_r == ADDR_W'(CELLS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + ADDR_W'(1);
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          cur_nxt = q_head;
          cnt_nxt = '0;
          if (q_head.clear) begin
            state_nxt = ST_CLR;
          end else if (q_head.wr_en) begin
            state_nxt = ST_WR;
          end else if (q_head.scroll) begin
            state_nxt = ST_SCR;
          end else if (q_head.rd_en) begin
            state_nxt = ST_RD;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_WR: begin
        mem_we    = 1'b1;
        mem_waddr = cur_r.addr;
        mem_wdata = {text_attr, cur_r.ch};
        state_nxt = cur_r.scroll ? ST_SCR : ST_DONE;
      end
      ST_SCR: begin
        mem_we    = 1'b1;
        mem_waddr = cur_r.scroll_base + cnt_r;
        if (cnt_r == ADDR_W'(COLUMNS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt = cnt_r + ADDR_W'(1);
        end
      end
      ST_CLR: begin
        mem_we = 1'b1;
        if (cnt_r == ADDR_W'(CELLS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt = cnt_r + ADDR_W'(1);
        end
      end
      ST_RD: begin
        mem_re    = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          load      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = load || (out_valid_r && out_stall);
  assign init_busy     = (state_r == ST_INIT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (load) begin
      out_col_r      <= cur_r.col;
      out_row_r      <= cur_r.row;
      out_cell_r     <= cur_r.rd_en ? mem_rdata : '0;
      out_scrolled_r <= cur_r.scroll;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cursor_col = out_col_r;
  assign out_cursor_row = out_row_r;
  assign out_cell_data  = out_cell_r;
  assign out_scrolled   = out_scrolled_r;

endmodule
